// ===== rtl/arpm_pkg.sv =====
// shared types and constants for the rms and peak level meter: controller states, command and status words
package arpm_pkg;

    localparam int               CH_W        = 1;
    localparam int               CFG_W       = 2;
    localparam logic [CFG_W-1:0] CHANS_RESET = 2'd2;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_ACCUM,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic accept;
        logic read;
        logic update;
        logic accum;
        logic sqrt_load;
        logic sqrt_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic active;
        logic block_end;
        logic count_last;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== rtl/arpm_ctrl.sv =====
// controller state machine sequencing one sample word through the datapath
module arpm_ctrl
    import arpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.active)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                if (!status.block_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT:
            begin
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (status.count_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_READ:      cmd.read      = 1'b1;
            ST_SQUARE:    cmd.update    = 1'b1;
            ST_ACCUM:     cmd.accum     = 1'b1;
            ST_SQRT_INIT: cmd.sqrt_load = 1'b1;
            ST_SQRT:      cmd.sqrt_step = 1'b1;
            ST_DONE:      cmd.out_load  = status.out_free;
            default:      cmd           = '0;
        endcase
    end

endmodule

// ===== rtl/arpm_datapath.sv =====
// datapath: window store, running sums of squares, block peaks, square root, output word
module arpm_datapath
    import arpm_pkg::*;
#(
    parameter int WINDOW      = 1024,
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [CFG_W-1:0]              active_channels,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    input  logic [CH_W-1:0]               channel,
    input  logic                          block_end,
    input  logic                          clear_clip,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [CH_W-1:0]               out_channel,
    output logic [SAMPLE_BITS-1:0]        rms_level,
    output logic [SAMPLE_BITS-1:0]        peak_level,
    output logic                          block_clip,
    output logic                          clip_latched,
    input  ctrl_cmd_t                     cmd,
    output ctrl_status_t                  status
);

    localparam int SB      = SAMPLE_BITS;
    localparam int LW      = $clog2(WINDOW);
    localparam int SUM_RAW = 2 * SB - 1 + LW;
    localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
    localparam int TW      = LW + 2 * SB + 1;
    localparam int SQ_W    = 2 * SB;
    localparam int PW      = (LW > 0) ? LW : 1;
    localparam int DEPTH   = CHANNELS * WINDOW;
    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(SB);
    localparam logic [SB-1:0] FULL_SCALE = SB'(1) << (SB - 2);
    localparam logic [TW-1:0] TOP_TERM   = TW'(WINDOW) << (2 * (SB - 1));

    function automatic logic [SB-1:0] magnitude(input logic [SB-1:0] bits);
        logic [SB-1:0] neg;
        neg = ~bits + SB'(1);
        return bits[SB-1] ? neg : bits;
    endfunction

    logic [CFG_W-1:0] cfg_reg;
    logic [CFG_W-1:0] chans_eff;

    logic [SB-1:0]    mem [DEPTH];
    logic [SB-1:0]    rdata_reg;

    logic [SB-1:0]    sample_reg;
    logic [CH_W-1:0]  ch_reg;
    logic             end_reg;

    logic [PW-1:0]    pos_reg  [CHANNELS];
    logic [CHANNELS-1:0] wrap_reg;
    logic [SUM_W-1:0] sum_reg  [CHANNELS];
    logic [SB-1:0]    peak_reg [CHANNELS];
    logic             sticky_reg;

    logic [SQ_W-1:0]  old_sq_reg;
    logic [SQ_W-1:0]  new_sq_reg;
    logic [SB-1:0]    peak_out_reg;
    logic             clip_reg;

    // window length times partial root and times current bit squared
    logic [TW-1:0]    rem_reg;
    logic [TW-1:0]    lin_reg;
    logic [TW-1:0]    sq_term_reg;
    logic [TW-1:0]    trial;
    logic             sqrt_ge;
    logic [SB-1:0]    root_reg;
    logic [CNT_W-1:0] count_reg;

    logic [AW-1:0]    addr;
    logic [SB-1:0]    mag_new;
    logic [SB-1:0]    mag_old;
    logic [SB-1:0]    peak_new;
    logic             clip_now;

    logic             out_valid_reg;
    logic [CH_W-1:0]  out_channel_reg;
    logic [SB-1:0]    rms_reg;
    logic [SB-1:0]    peak_level_reg;
    logic             block_clip_reg;
    logic             clip_latched_reg;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            chans_eff = CFG_W'(1);
        end
        else if (32'(cfg_reg) > CHANNELS)
        begin
            chans_eff = CFG_W'(CHANNELS);
        end
        else
        begin
            chans_eff = cfg_reg;
        end
    end

    assign addr     = AW'(ch_reg) * AW'(WINDOW) + AW'(pos_reg[ch_reg]);
    assign mag_new  = magnitude(sample_reg);
    assign mag_old  = wrap_reg[ch_reg] ? magnitude(rdata_reg) : '0;
    assign peak_new = (mag_new > peak_reg[ch_reg]) ? mag_new : peak_reg[ch_reg];
    assign clip_now = (peak_new >= FULL_SCALE);

    assign trial    = lin_reg + sq_term_reg;
    assign sqrt_ge  = (rem_reg >= trial);

    assign status.active     = (32'(channel) < 32'(chans_eff));
    assign status.block_end  = end_reg;
    assign status.count_last = (count_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    // configuration and sticky clip latch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= CHANS_RESET;
            sticky_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= active_channels;
            end
            if (cmd.accept && clear_clip)
            begin
                sticky_reg <= 1'b0;
            end
            else if (cmd.update && end_reg && clip_now)
            begin
                sticky_reg <= 1'b1;
            end
        end
    end

    // window store, one sample word per entry
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rdata_reg <= mem[addr];
        end
        if (cmd.update)
        begin
            mem[addr] <= sample_reg;
        end
    end

    // per channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i]  <= '0;
                sum_reg[i]  <= '0;
                peak_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.update)
            begin
                if (32'(pos_reg[ch_reg]) == WINDOW - 1)
                begin
                    pos_reg[ch_reg]  <= '0;
                    wrap_reg[ch_reg] <= 1'b1;
                end
                else
                begin
                    pos_reg[ch_reg] <= pos_reg[ch_reg] + PW'(1);
                end
                peak_reg[ch_reg] <= end_reg ? '0 : peak_new;
            end
            if (cmd.accum)
            begin
                sum_reg[ch_reg] <= sum_reg[ch_reg] - SUM_W'(old_sq_reg) + SUM_W'(new_sq_reg);
            end
        end
    end

    // sample capture, squares, peak and clip of the finished block
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample_value;
            ch_reg     <= channel;
            end_reg    <= block_end;
        end
        if (cmd.update)
        begin
            old_sq_reg <= mag_old * mag_old;
            new_sq_reg <= mag_new * mag_new;
            if (end_reg)
            begin
                peak_out_reg <= peak_new;
                clip_reg     <= clip_now;
            end
        end
    end

    // bit-serial square root of sum / WINDOW, largest root with WINDOW * root^2 <= sum
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            rem_reg     <= TW'(sum_reg[ch_reg]);
            lin_reg     <= '0;
            sq_term_reg <= TOP_TERM;
            root_reg    <= '0;
            count_reg   <= CNT_W'(SB - 1);
        end
        else if (cmd.sqrt_step)
        begin
            if (sqrt_ge)
            begin
                rem_reg <= rem_reg - trial;
                lin_reg <= (lin_reg >> 1) + sq_term_reg;
            end
            else
            begin
                lin_reg <= lin_reg >> 1;
            end
            sq_term_reg <= sq_term_reg >> 2;
            root_reg    <= {root_reg[SB-2:0], sqrt_ge};
            count_reg   <= count_reg - CNT_W'(1);
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_channel_reg  <= ch_reg;
            rms_reg          <= root_reg;
            peak_level_reg   <= peak_out_reg;
            block_clip_reg   <= clip_reg;
            clip_latched_reg <= sticky_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_channel  = out_channel_reg;
    assign rms_level    = rms_reg;
    assign peak_level   = peak_level_reg;
    assign block_clip   = block_clip_reg;
    assign clip_latched = clip_latched_reg;

endmodule

// ===== rtl/audio_rms_peak_meter.sv =====
// top level of the sliding-window rms and block peak level meter
//
// Each input word is one signed Q2.22 sample for one channel. Per channel the meter keeps
// the last WINDOW samples and the sum of their squares; a word with block_end reports
// floor(sqrt(sum / WINDOW)), the block peak magnitude, a clip flag (peak >= 1.0) and the
// sticky clip latch, which clear_clip resets. Words for channels at or above the active
// count (0 counts as 1, values above CHANNELS as CHANNELS) are dropped, but their clear_clip
// still acts. A sample word passes through accept, store read, squaring and sum update; a
// block end then runs the bit-serial square root (load, root steps, output load), one root
// bit a cycle, with the window length folded into the trial terms so no divider is needed.
// A result waits in the output register while the next sample is taken; a block end that
// finds that register still full holds the input until it drains. Unwritten window entries
// read as zero through a per-channel wrap flag, so no clearing pass follows reset.
module audio_rms_peak_meter
    import arpm_pkg::*;
#(
    parameter int WINDOW      = 1024,
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_W-1:0]              active_channels,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    input  logic [CH_W-1:0]               channel,
    input  logic                          block_end,
    input  logic                          clear_clip,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [CH_W-1:0]               out_channel,
    output logic [SAMPLE_BITS-1:0]        rms_level,
    output logic [SAMPLE_BITS-1:0]        peak_level,
    output logic                          block_clip,
    output logic                          clip_latched
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    arpm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    arpm_datapath
    #(
        .WINDOW      (WINDOW),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .active_channels (active_channels),
        .sample_value    (sample_value),
        .channel         (channel),
        .block_end       (block_end),
        .clear_clip      (clear_clip),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .out_channel     (out_channel),
        .rms_level       (rms_level),
        .peak_level      (peak_level),
        .block_clip      (block_clip),
        .clip_latched    (clip_latched),
        .cmd             (cmd),
        .status          (status)
    );

endmodule
